// ----- hdl/move_immediate_encoder_assert.svh -----
// Assertion macros shared by the move immediate encoder modules.
`ifndef MOVE_IMMEDIATE_ENCODER_ASSERT_SVH
`define MOVE_IMMEDIATE_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MIE_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MIE_ASSERT(lbl, prop, msg)
`define MIE_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/mie_pkg.sv -----
// Types, opcodes and constants of the move immediate encoder.
package mie_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_X = 1'b0;
    localparam logic FUNC_W = 1'b1;

    localparam logic [31:0] OP_MOVN_X = 32'h9280_0000;
    localparam logic [31:0] OP_MOVK_X = 32'hF280_0000;
    localparam logic [31:0] OP_MOVZ_X = 32'hD280_0000;
    localparam logic [31:0] OP_MOVZ_W = 32'h5280_0000;
    localparam logic [31:0] OP_MOVK_W = 32'h7280_0000;
    localparam logic [15:0] PIECE_ONES = 16'hFFFF;

    typedef struct packed {
        logic        func;
        logic [4:0]  dest_reg;
        logic [63:0] imm_value;
    } item_t;

    typedef struct packed {
        logic [31:0] insn_word;
        logic        last;
    } insn_t;

    // Classified item: which pieces to emit, and whether the leading word is MOVN.
    typedef struct packed {
        logic             func;
        logic [4:0]       dest_reg;
        logic [3:0][15:0] pieces;
        logic             invert;
        logic [3:0]       mask;
    } plan_t;

endpackage

// ----- hdl/mie_front.sv -----
// Front end: accepts an item and classifies it into an emission plan.
module mie_front (
    input  logic           item_valid,
    output logic           item_stall,
    input  mie_pkg::item_t item,
    input  logic           q_full,
    output logic           push,
    output mie_pkg::plan_t push_plan
);
    import mie_pkg::*;

    logic [3:0][15:0] pieces;
    logic [3:0]       nz;
    logic [3:0]       nones;
    logic [2:0]       nz_cnt;
    logic [2:0]       nones_cnt;
    logic             use_movn;
    logic [3:0]       x_mask;
    logic [3:0]       w_mask;

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    always_comb
    begin
        pieces = item.imm_value;
        for (int i = 0; i < 4; i++)
        begin
            nz[i]    = (pieces[i] != 16'h0000);
            nones[i] = (pieces[i] != PIECE_ONES);
        end
        nz_cnt    = 3'($countones(nz));
        nones_cnt = 3'($countones(nones));
        use_movn  = (nones_cnt < nz_cnt);

        // Zero or all-ones values still need one word for piece 0.
        x_mask = use_movn ? nones : nz;
        if (x_mask == 4'b0000)
        begin
            x_mask = 4'b0001;
        end

        // Zero low half with a live high half: a single shifted MOVZ.
        if (nz[1] && !nz[0])
        begin
            w_mask = 4'b0010;
        end
        else
        begin
            w_mask = {2'b00, nz[1], 1'b1};
        end

        push_plan.func     = item.func;
        push_plan.dest_reg = item.dest_reg;
        push_plan.pieces   = pieces;
        push_plan.invert   = (item.func == FUNC_X) && use_movn;
        push_plan.mask     = (item.func == FUNC_W) ? w_mask : x_mask;
    end

endmodule

// ----- hdl/mie_queue.sv -----
// Short plan queue between the front end and the word sequencer.
module mie_queue #(
    parameter int Depth = mie_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mie_pkg::plan_t push_plan,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mie_pkg::plan_t head_plan
);
    import mie_pkg::*;

    `include "move_immediate_encoder_assert.svh"

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    plan_t            entries_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_plan  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_plan;
        end
    end

    `MIE_ASSERT(a_count_bound, count_reg <= CntW'(Depth), "queue count beyond depth")
    `MIE_ASSERT(a_push_full, push && full |=> count_reg == CntW'(Depth), "push lost on full queue")
    `MIE_ASSERT(a_pop_empty, pop && !head_valid |=> count_reg == '0 || $past(push), "pop from empty queue")

endmodule

// ----- hdl/mie_back.sv -----
// Back end: steps through a plan and emits one instruction word per cycle while insn_stall is low.
module mie_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  mie_pkg::plan_t head_plan,
    output logic           pop,
    output logic           insn_valid,
    input  logic           insn_stall,
    output mie_pkg::insn_t insn
);
    import mie_pkg::*;

    `include "move_immediate_encoder_assert.svh"

    logic        cur_valid_reg;
    plan_t       cur_plan_reg;
    logic        cur_first_reg;
    logic        out_valid_reg;
    insn_t       out_reg;
    insn_t       out_next;
    logic        advance;
    logic        emit;
    logic        done;
    logic        load;
    logic [1:0]  idx;
    logic [3:0]  sel;
    logic [15:0] piece;
    logic [15:0] imm16;
    logic [31:0] base;
    logic        last_word;

    assign advance = !out_valid_reg || !insn_stall;
    assign emit    = advance && cur_valid_reg;
    assign done    = emit && last_word;
    assign load    = (!cur_valid_reg || done) && head_valid;
    assign pop     = load;

    assign insn_valid = out_valid_reg;
    assign insn       = out_reg;

    always_comb
    begin
        // Lowest pending piece goes next; the first one is the leading MOVZ or MOVN.
        if (cur_plan_reg.mask[0])
        begin
            idx = 2'd0;
        end
        else if (cur_plan_reg.mask[1])
        begin
            idx = 2'd1;
        end
        else if (cur_plan_reg.mask[2])
        begin
            idx = 2'd2;
        end
        else
        begin
            idx = 2'd3;
        end
        sel       = 4'b0001 << idx;
        last_word = ((cur_plan_reg.mask & ~sel) == 4'b0000);
        piece     = cur_plan_reg.pieces[idx];
        imm16     = (cur_first_reg && cur_plan_reg.invert) ? ~piece : piece;

        if (cur_plan_reg.func == FUNC_W)
        begin
            base = cur_first_reg ? OP_MOVZ_W : OP_MOVK_W;
        end
        else if (cur_first_reg)
        begin
            base = cur_plan_reg.invert ? OP_MOVN_X : OP_MOVZ_X;
        end
        else
        begin
            base = OP_MOVK_X;
        end

        out_next.insn_word = base | {9'b0, idx, imm16, cur_plan_reg.dest_reg};
        out_next.last      = last_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                cur_first_reg <= 1'b1;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                cur_first_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_plan_reg <= head_plan;
        end
        else if (emit)
        begin
            // Drop the piece just emitted.
            cur_plan_reg.mask <= cur_plan_reg.mask & ~sel;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    `MIE_ASSERT(a_mask_live, cur_valid_reg |-> cur_plan_reg.mask != 4'b0000, "active plan with no pieces")
    `MIE_ASSERT(a_emit_shows, emit |=> insn_valid, "emitted word not presented")
    `MIE_ASSERT(a_mid_seq, emit && !last_word |=> cur_valid_reg && !cur_first_reg, "sequence cut short")
    `MIE_ASSERT_NEVER(a_w_no_movn, cur_valid_reg && cur_plan_reg.func == FUNC_W && cur_plan_reg.invert, "MOVN planned in W mode")

endmodule

// ----- hdl/move_immediate_encoder.sv -----
// Move immediate encoder: one item in, one to four MOVZ/MOVN/MOVK words out.
// The first word passes through the plan queue, the sequencer's plan register and the output register.
// Throughput: one word per cycle while insn_stall is low; an item yields 1 to 4 words,
// sent one after another from the sequencer's single output register.
// The plan queue holds QueueDepth items so intake continues while words drain.
// Reset (rst_n low, asynchronous) empties the queue, the sequencer and the output register.
module move_immediate_encoder #(
    parameter int QueueDepth = mie_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  mie_pkg::item_t item,
    output logic           insn_valid,
    input  logic           insn_stall,
    output mie_pkg::insn_t insn
);
    import mie_pkg::*;

    logic  q_full;
    logic  push;
    plan_t push_plan;
    logic  pop;
    logic  head_valid;
    plan_t head_plan;

    mie_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_plan  (push_plan)
    );

    mie_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_plan  (push_plan),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_plan  (head_plan)
    );

    mie_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_plan  (head_plan),
        .pop        (pop),
        .insn_valid (insn_valid),
        .insn_stall (insn_stall),
        .insn       (insn)
    );

endmodule

// ----- tb/sv/move_immediate_checker.sv -----
// Checker for the move immediate encoder: predicts instruction words and compares them.
`timescale 1ns / 100ps

module move_immediate_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_stall,
    input  mie_pkg::item_t  item,
    input  logic            insn_valid,
    input  logic            insn_stall,
    input  mie_pkg::insn_t  insn,
    output int              fail_count,
    output int              pending_count,
    output int              words_seen
);
    import mie_pkg::*;

    insn_t expected_words[$];

    function automatic logic [31:0] wide_move(input logic [31:0] opcode, input logic [1:0] hw,
                                              input logic [15:0] imm16, input logic [4:0] rd);
        return opcode | {9'd0, hw, imm16, rd};
    endfunction

    // Append the MOVZ/MOVN/MOVK sequence that loads one immediate.
    function automatic void predict_move_sequence(input item_t it);
        insn_t            seq[4];
        int               n;
        logic [15:0]      lo;
        logic [15:0]      hi;
        logic [3:0][15:0] pieces;
        int               nonzero;
        int               nonones;
        logic [15:0]      skip;
        int               lead;
        bit               found;
        n       = 0;
        lo      = it.imm_value[15:0];
        hi      = it.imm_value[31:16];
        pieces  = it.imm_value;
        nonzero = 0;
        nonones = 0;
        lead    = 0;
        found   = 0;
        if (it.func == FUNC_W)
        begin
            if (hi != 16'd0 && lo == 16'd0)
            begin
                seq[n].insn_word = wide_move(OP_MOVZ_W, 2'd1, hi, it.dest_reg);
                n++;
            end
            else
            begin
                seq[n].insn_word = wide_move(OP_MOVZ_W, 2'd0, lo, it.dest_reg);
                n++;
                if (hi != 16'd0)
                begin
                    seq[n].insn_word = wide_move(OP_MOVK_W, 2'd1, hi, it.dest_reg);
                    n++;
                end
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (pieces[i] != 16'd0)
                    nonzero++;
                if (pieces[i] != PIECE_ONES)
                    nonones++;
            end
            // Skip whichever filler value leaves fewer words to emit.
            skip = (nonones < nonzero) ? PIECE_ONES : 16'd0;
            for (int i = 0; i < 4; i++)
            begin
                if (!found && pieces[i] != skip)
                begin
                    lead  = i;
                    found = 1;
                end
            end
            if (skip == PIECE_ONES)
                seq[n].insn_word = wide_move(OP_MOVN_X, lead[1:0], ~pieces[lead], it.dest_reg);
            else
                seq[n].insn_word = wide_move(OP_MOVZ_X, lead[1:0], pieces[lead], it.dest_reg);
            n++;
            for (int i = 0; i < 4; i++)
            begin
                if (i != lead && pieces[i] != skip)
                begin
                    seq[n].insn_word = wide_move(OP_MOVK_X, i[1:0], pieces[i], it.dest_reg);
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            seq[i].last = (i == n - 1);
            expected_words.insert(expected_words.size(), seq[i]);
        end
    endfunction

    always @(posedge clk)
    begin
        insn_t want;
        if (!rst_n)
        begin
            fail_count    <= 0;
            pending_count <= 0;
            words_seen    <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_move_sequence(item);
            if (insn_valid && !insn_stall)
            begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word: insn_word %h last %b",
                             $time, insn.insn_word, insn.last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (insn.insn_word !== want.insn_word)
                    begin
                        $display("%0t: insn_word mismatch: expected %h, actual %h",
                                 $time, want.insn_word, insn.insn_word);
                        fail_count <= fail_count + 1;
                    end
                    else if (insn.last !== want.last)
                    begin
                        $display("%0t: last mismatch on word %h: expected %b, actual %b",
                                 $time, want.insn_word, want.last, insn.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_words.size();
        end
    end

endmodule

// ----- tb/sv/move_immediate_encoder_tb.sv -----
// Testbench top for the move immediate encoder: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module move_immediate_encoder_tb;
    import mie_pkg::*;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  item_valid = 1'b0;
    logic  item_stall;
    item_t item       = '0;
    logic  insn_valid;
    logic  insn_stall = 1'b0;
    insn_t insn;

    int fail_count;
    int pending_count;
    int words_seen;
    int items_sent          = 0;
    int sender_idle_pct     = 0;
    int receiver_stall_pct  = 0;

    move_immediate_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .insn_valid (insn_valid),
        .insn_stall (insn_stall),
        .insn       (insn)
    );

    move_immediate_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .insn_valid    (insn_valid),
        .insn_stall    (insn_stall),
        .insn          (insn),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_seen    (words_seen)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        insn_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    // Call at a rising edge; returns at the edge where the item is taken.
    task automatic send_move(input logic func, input logic [4:0] rd, input logic [63:0] imm);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= '{func: func, dest_reg: rd, imm_value: imm};
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Pieces drawn mostly from zero, all ones and sparse values to steer the MOVN/MOVZ choice.
    function automatic logic [63:0] shaped_immediate();
        logic [3:0][15:0] pieces;
        logic [15:0]      one_bit;
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            one_bit = 16'd1 << $urandom_range(0, 15);
            case ($urandom_range(0, 4))
                0: pieces[i] = 16'h0000;
                1: pieces[i] = PIECE_ONES;
                2: pieces[i] = one_bit;
                3: pieces[i] = ~one_bit;
                default: pieces[i] = 16'($urandom_range(0, 16'hFFFF));
            endcase
        end
        return pieces;
    endfunction

    task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
            send_move(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      shaped_immediate());
    endtask

    initial
    begin
        #1ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 64-bit moves: zero, all ones, single pieces, ties and full sequences
        send_move(FUNC_X, 5'd0,  64'h0000_0000_0000_0000);
        send_move(FUNC_X, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        send_move(FUNC_X, 5'd1,  64'h0000_0000_0000_1234);
        send_move(FUNC_X, 5'd2,  64'h0000_0000_ABCD_0000);
        send_move(FUNC_X, 5'd3,  64'h0000_8000_0000_0000);
        send_move(FUNC_X, 5'd4,  64'hFFFF_0000_0000_0000);
        send_move(FUNC_X, 5'd5,  64'h0000_FFFF_0000_FFFF);
        send_move(FUNC_X, 5'd6,  64'hFFFF_FFFF_1234_FFFF);
        send_move(FUNC_X, 5'd7,  64'h5678_FFFF_FFFF_FFFF);
        send_move(FUNC_X, 5'd8,  64'hFFFF_FFFF_FFFF_0000);
        send_move(FUNC_X, 5'd9,  64'h1234_5678_9ABC_DEF0);
        send_move(FUNC_X, 5'd10, 64'h8000_0000_0000_0001);
        send_move(FUNC_X, 5'd11, 64'hFFFF_0001_FFFF_8000);
        // 32-bit moves: upper half ignored, low and high halves in every combination
        send_move(FUNC_W, 5'd0,  64'h0000_0000_0000_0000);
        send_move(FUNC_W, 5'd31, 64'hFFFF_FFFF_0000_0000);
        send_move(FUNC_W, 5'd12, 64'h0000_0000_0000_BEEF);
        send_move(FUNC_W, 5'd13, 64'h0000_0000_CAFE_0000);
        send_move(FUNC_W, 5'd14, 64'h0000_0000_CAFE_BEEF);
        send_move(FUNC_W, 5'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_move(FUNC_W, 5'd16, 64'hA5A5_5A5A_8000_0001);

        random_phase(0, 0, 90);
        random_phase(49, 0, 90);
        random_phase(0, 49, 90);
        random_phase(6, 6, 90);

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d move items (64-bit and 32-bit), checked %0d instruction words",
                 items_sent, words_seen);
        $display("Idle patterns: none, sender gaps, receiver stalls, and both together");
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mie_pkg.sv
hdl/mie_front.sv
hdl/mie_queue.sv
hdl/mie_back.sv
hdl/move_immediate_encoder.sv
tb/sv/move_immediate_checker.sv
tb/sv/move_immediate_encoder_tb.sv
